// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the server select block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/whss_pkg.sv -----
// ----------------------------------------------------------------------------
// whss_pkg
// Types and constants of the weighted hash server select block.
// ----------------------------------------------------------------------------
package whss_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int SRV_BITS    = 4;
  localparam int CNT_BITS    = 5;
  localparam int SLOT_COUNT  = 256;
  localparam int SLOT_BITS   = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int TOTAL_BITS  = 12;
  localparam int SHARE_BITS  = 9;
  localparam int PROD_BITS   = 16;

  localparam logic [SLOT_BITS-1:0] SLOT_STRIDE = 8'd3;

  localparam logic CFG_SERVER_COUNT = 1'b0;
  localparam logic CFG_PORT_MIXING  = 1'b1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SHARE,
    ST_DIV,
    ST_POST,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                   op;
    logic [SRV_BITS-1:0]    server_index;
    logic [WEIGHT_BITS-1:0] server_weight;
    logic                   server_available;
    logic [SLOT_BITS-1:0]   hash;
  } item_t;

endpackage

// ----- hdl/whss_req_if.sv -----
// ----------------------------------------------------------------------------
// whss_req_if
// Request channel carrying update and lookup items.
// ----------------------------------------------------------------------------
interface whss_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  server_index;
  logic [7:0]  server_weight;
  logic        server_available;
  logic [31:0] client_ip;
  logic [15:0] client_port;

  modport source (output valid, op, server_index, server_weight, server_available,
                  client_ip, client_port, input ready);
  modport sink (input valid, op, server_index, server_weight, server_available,
                client_ip, client_port, output ready);
endinterface

// ----- hdl/whss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// whss_rsp_if
// Response channel carrying the selected server.
// ----------------------------------------------------------------------------
interface whss_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] selected_server;
  logic       none_avail;

  modport source (output valid, selected_server, none_avail, input ready);
  modport sink (input valid, selected_server, none_avail, output ready);
endinterface

// ----- hdl/whss_front.sv -----
// ----------------------------------------------------------------------------
// whss_front
// Accepts items, computes the client hash and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module whss_front (
  input  logic           clk,
  input  logic           rst,
  whss_req_if.sink       req,
  input  logic           port_mixing,
  output logic           q_valid,
  output whss_pkg::item_t q_item,
  input  logic           q_pop
);

  whss_pkg::item_t fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic [7:0] hash;
  whss_pkg::item_t item;

  always_comb begin
    hash = req.client_ip[7:0] ^ req.client_ip[15:8] ^ req.client_ip[23:16]
         ^ req.client_ip[31:24];
    if (port_mixing) begin
      hash = hash ^ req.client_port[7:0] ^ req.client_port[15:8];
    end
    item.op               = req.op;
    item.server_index     = req.server_index;
    item.server_weight    = req.server_weight;
    item.server_available = req.server_available;
    item.hash             = hash;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/whss_back.sv -----
// ----------------------------------------------------------------------------
// whss_back
// Executes queued items: table updates, slot table rebuild and lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whss_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  whss_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [4:0]      server_count,
  input  logic            cfg_clear,
  whss_rsp_if.source      rsp
);

  whss_pkg::state_t state, state_next;

  logic [whss_pkg::WEIGHT_BITS-1:0] weight_tbl [whss_pkg::MAX_SERVERS];
  logic [whss_pkg::MAX_SERVERS-1:0] avail_tbl;
  logic [whss_pkg::SHARE_BITS-1:0]  share [whss_pkg::MAX_SERVERS];
  logic [whss_pkg::SRV_BITS-1:0]    slot_mem [whss_pkg::SLOT_COUNT];
  logic [whss_pkg::SRV_BITS-1:0]    rd_data;

  logic                             table_valid;
  logic [whss_pkg::CNT_BITS-1:0]    k;
  logic [whss_pkg::CNT_BITS-1:0]    n_act;
  logic [whss_pkg::TOTAL_BITS-1:0]  total;
  logic [whss_pkg::SHARE_BITS-1:0]  left;
  logic [whss_pkg::SLOT_BITS-1:0]   hash;
  logic                             none_flag;
  logic [whss_pkg::TOTAL_BITS:0]    rem;
  logic [whss_pkg::PROD_BITS-1:0]   quo;
  logic [3:0]                       div_cnt;
  logic [whss_pkg::WEIGHT_BITS-1:0] cur_s;
  logic [whss_pkg::SRV_BITS-1:0]    srv;
  logic [whss_pkg::SLOT_BITS-1:0]   slot;
  logic [whss_pkg::SHARE_BITS-1:0]  fill_cnt;

  logic [whss_pkg::WEIGHT_BITS-1:0] w_eff;
  logic [whss_pkg::TOTAL_BITS:0]    rem_sh;
  logic [whss_pkg::PROD_BITS-1:0]   prod;
  logic                             k_done;
  logic                             out_free;
  logic                             rsp_valid;
  logic [whss_pkg::SRV_BITS-1:0]    rsp_sel;
  logic                             rsp_none;

  assign n_act  = (server_count > 5'd16) ? 5'd16 : server_count;
  assign k_done = (k == n_act);
  assign w_eff  = (weight_tbl[k[3:0]] == '0) ? 8'd1 : weight_tbl[k[3:0]];
  assign rem_sh = {rem[whss_pkg::TOTAL_BITS-1:0], quo[whss_pkg::PROD_BITS-1]};
  assign prod   = 16'(left) * 16'(w_eff);
  assign out_free = !rsp_valid || rsp.ready;

  assign rsp.valid           = rsp_valid;
  assign rsp.selected_server = rsp_sel;
  assign rsp.none_avail      = rsp_none;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= whss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      whss_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == whss_pkg::OP_LOOKUP) begin
            state_next = table_valid ? whss_pkg::ST_READ : whss_pkg::ST_SUM;
          end
        end
      end
      whss_pkg::ST_SUM: begin
        if (k_done) begin
          state_next = (total == '0) ? whss_pkg::ST_RESP : whss_pkg::ST_SHARE;
        end
      end
      whss_pkg::ST_SHARE: begin
        if (k_done) begin
          state_next = whss_pkg::ST_FILL;
        end else if (avail_tbl[k[3:0]]) begin
          state_next = whss_pkg::ST_DIV;
        end
      end
      whss_pkg::ST_DIV: begin
        if (div_cnt == 4'd15) begin
          state_next = whss_pkg::ST_POST;
        end
      end
      whss_pkg::ST_POST: state_next = whss_pkg::ST_SHARE;
      whss_pkg::ST_FILL: begin
        if (fill_cnt == 9'd256) begin
          state_next = whss_pkg::ST_READ;
        end
      end
      whss_pkg::ST_READ: state_next = whss_pkg::ST_RESP;
      whss_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = whss_pkg::ST_IDLE;
        end
      end
      default: state_next = whss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= slot_mem[hash];
    if (state == whss_pkg::ST_FILL && fill_cnt != 9'd256 && share[srv] != '0) begin
      slot_mem[slot] <= srv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < whss_pkg::MAX_SERVERS; i++) begin
        weight_tbl[i] <= '0;
      end
      avail_tbl   <= '0;
      table_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != whss_pkg::ST_RESP) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_clear && state != whss_pkg::ST_IDLE && state != whss_pkg::ST_FILL) begin
        table_valid <= 1'b0;
      end
      case (state)
        whss_pkg::ST_IDLE: begin
          k     <= '0;
          total <= '0;
          hash  <= q_item.hash;
          none_flag <= 1'b0;
          if (q_valid && q_item.op == whss_pkg::OP_UPDATE) begin
            weight_tbl[q_item.server_index] <= q_item.server_weight;
            avail_tbl[q_item.server_index]  <= q_item.server_available;
          end
          if (cfg_clear || (q_valid && q_item.op == whss_pkg::OP_UPDATE)) begin
            table_valid <= 1'b0;
          end
        end
        whss_pkg::ST_SUM: begin
          if (k_done) begin
            k    <= '0;
            left <= 9'd256;
            none_flag <= (total == '0);
          end else begin
            if (avail_tbl[k[3:0]]) begin
              total <= total + 12'(w_eff);
            end
            k <= k + 5'd1;
          end
        end
        whss_pkg::ST_SHARE: begin
          srv      <= '0;
          slot     <= '0;
          fill_cnt <= '0;
          if (!k_done) begin
            if (avail_tbl[k[3:0]]) begin
              quo     <= prod;
              rem     <= '0;
              div_cnt <= '0;
              cur_s   <= w_eff;
            end else begin
              share[k[3:0]] <= '0;
              k <= k + 5'd1;
            end
          end
        end
        whss_pkg::ST_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (rem_sh >= {1'b0, total}) begin
            rem <= rem_sh - {1'b0, total};
            quo <= {quo[whss_pkg::PROD_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[whss_pkg::PROD_BITS-2:0], 1'b0};
          end
        end
        whss_pkg::ST_POST: begin
          share[k[3:0]] <= quo[whss_pkg::SHARE_BITS-1:0];
          left  <= left - quo[whss_pkg::SHARE_BITS-1:0];
          total <= total - 12'(cur_s);
          k     <= k + 5'd1;
        end
        whss_pkg::ST_FILL: begin
          if (fill_cnt == 9'd256) begin
            table_valid <= !cfg_clear;
          end else if (share[srv] == '0) begin
            srv <= srv + 4'd1;
          end else begin
            share[srv] <= share[srv] - 9'd1;
            slot       <= slot + whss_pkg::SLOT_STRIDE;
            fill_cnt   <= fill_cnt + 9'd1;
          end
        end
        whss_pkg::ST_RESP: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp_none  <= none_flag;
            rsp_sel   <= none_flag ? '0 : rd_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_CLK(a_div_nonzero, clk, rst, (state == whss_pkg::ST_DIV) |-> (total != '0), "divide by zero total")
  `ASSERT_CLK(a_valid_after_fill, clk, rst, $rose(table_valid) |-> ($past(state) == whss_pkg::ST_FILL), "table valid set outside fill")
  `ASSERT_CLK(a_fill_bound, clk, rst, (state == whss_pkg::ST_FILL) |-> (fill_cnt <= 9'd256), "fill count overrun")
  `ASSERT_CLK(a_none_sel_zero, clk, rst, (rsp_valid && rsp_none) |-> (rsp_sel == '0), "server nonzero with no server")

endmodule

// ----- hdl/weighted_hash_server_select.sv -----
// ----------------------------------------------------------------------------
// weighted_hash_server_select
// Weighted hash load balancer with a rebuilt 256-slot server table.
//
// Channel  Dir  Contents
// req      in   op, server_index, server_weight, server_available, ip, port
// rsp      out  selected_server, none_avail (one per lookup)
// cfg      in   cfg_we, cfg_index, cfg_wdata
//
// An update is written to the tables as the back end dequeues it; a lookup
// with a valid table goes through dequeue, slot memory read and result register.
// A lookup on a stale table first rebuilds it: a weight sum over the servers
// in use, a 16-step serial divide per available server, then 256 slot writes,
// stepping past spent servers; with none available it answers none_avail.
// Reset is synchronous; the slot memory is not cleared.
// A two-entry queue lets the request side keep filling while the back end
// works or the response side stalls.
// ----------------------------------------------------------------------------
module weighted_hash_server_select (
  input  logic       clk,
  input  logic       rst,
  whss_req_if.sink   req,
  whss_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);

  logic [4:0]      server_count;
  logic            port_mixing;
  logic            cfg_clear;
  logic            q_valid;
  logic            q_pop;
  whss_pkg::item_t q_item;

  assign cfg_clear = cfg_we && (cfg_index == whss_pkg::CFG_SERVER_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= 5'd1;
      port_mixing  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == whss_pkg::CFG_SERVER_COUNT) begin
        server_count <= cfg_wdata;
      end else begin
        port_mixing <= cfg_wdata[0];
      end
    end
  end

  whss_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .port_mixing (port_mixing),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  whss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .server_count (server_count),
    .cfg_clear    (cfg_clear),
    .rsp          (rsp)
  );

endmodule

// ----- tb/sv/weighted_hash_server_select_tb.sv -----
// ----------------------------------------------------------------------------
// weighted_hash_server_select_tb
// Self-checking bench for the weighted hash server select block. A directed
// table covers reset state, weight and count extremes and the no-server case,
// then random update and lookup traffic runs under several idling patterns
// and register settings. Every lookup result is checked against a predictor
// that rebuilds its own slot table.
// ----------------------------------------------------------------------------
module weighted_hash_server_select_tb;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [7:0]  weight;
    logic        avail;
    logic [31:0] ip;
    logic [15:0] port;
    logic        known;
    logic [3:0]  want_srv;
    logic        want_none;
  } stim_t;

  typedef struct {
    logic [3:0] srv;
    logic       none;
  } choice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = whss_pkg::CFG_SERVER_COUNT;
  logic [4:0] cfg_wdata = '0;

  whss_req_if req ();
  whss_rsp_if rsp ();

  weighted_hash_server_select u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  logic [4:0] m_count;
  logic       m_mixing;
  logic [7:0] m_weight [whss_pkg::MAX_SERVERS];
  logic       m_avail [whss_pkg::MAX_SERVERS];
  logic [3:0] m_slots [whss_pkg::SLOT_COUNT];
  logic       m_valid;
  choice_t    pending_choices [$];
  int         errors = 0;
  int         lookups_seen = 0;
  int         none_seen = 0;
  int         send_idle = 0;
  int         recv_stall = 0;
  bit         hold_off = 0;

  function automatic bit rebuild_slots();
    int n, total, left, slot, srv, w;
    int share [whss_pkg::MAX_SERVERS];
    n = (m_count > whss_pkg::MAX_SERVERS) ? whss_pkg::MAX_SERVERS : m_count;
    total = 0;
    for (int k = 0; k < whss_pkg::MAX_SERVERS; k++) begin
      share[k] = 0;
      if (k < n && m_avail[k]) begin
        share[k] = (m_weight[k] == 0) ? 1 : m_weight[k];
        total += share[k];
      end
    end
    if (total == 0) return 0;
    left = whss_pkg::SLOT_COUNT;
    for (int k = 0; k < n; k++) begin
      if (m_avail[k]) begin
        w = left * share[k] / total;
        left -= w;
        total -= share[k];
        share[k] = w;
      end
    end
    srv = 0;
    slot = 0;
    for (int k = 0; k < whss_pkg::SLOT_COUNT; k++) begin
      while (srv < n && share[srv] == 0) srv++;
      if (srv >= n) srv = n - 1;
      m_slots[slot] = srv[3:0];
      if (share[srv] > 0) share[srv]--;
      slot = (slot + 3) % whss_pkg::SLOT_COUNT;
    end
    m_valid = 1;
    return 1;
  endfunction

  function automatic void predict_item(stim_t s);
    choice_t c;
    logic [7:0] h;
    if (s.op == whss_pkg::OP_UPDATE) begin
      m_weight[s.idx] = s.weight;
      m_avail[s.idx] = s.avail;
      m_valid = 0;
      return;
    end
    h = s.ip[7:0] ^ s.ip[15:8] ^ s.ip[23:16] ^ s.ip[31:24];
    if (m_mixing) h ^= s.port[7:0] ^ s.port[15:8];
    if (!m_valid && !rebuild_slots()) begin
      c.srv = 0;
      c.none = 1;
    end else begin
      c.srv = m_slots[h];
      c.none = 0;
    end
    if (s.known && (c.srv !== s.want_srv || c.none !== s.want_none)) begin
      $error("directed row disagrees with predictor: srv %0d/%0d none %0d/%0d",
             s.want_srv, c.srv, s.want_none, c.none);
      errors++;
    end
    pending_choices.push_back(c);
  endfunction

  task automatic send_item(stim_t s);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= s.op;
    req.server_index <= s.idx;
    req.server_weight <= s.weight;
    req.server_available <= s.avail;
    req.client_ip <= s.ip;
    req.client_port <= s.port;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_item(s);
  endtask

  task automatic write_register(logic which, logic [4:0] value);
    req.valid <= 1'b0;
    wait (pending_choices.size() == 0);
    repeat (700) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == whss_pkg::CFG_SERVER_COUNT) begin
      m_count = value;
      m_valid = 0;
    end else begin
      m_mixing = value[0];
    end
  endtask

  function automatic stim_t random_item(int update_pct);
    stim_t s;
    s.op = ($urandom_range(99) < update_pct) ? whss_pkg::OP_UPDATE : whss_pkg::OP_LOOKUP;
    s.idx = 4'($urandom_range(15));
    case ($urandom_range(3))
      0: s.weight = 8'd0;
      1: s.weight = 8'hff;
      default: s.weight = 8'($urandom_range(255));
    endcase
    s.avail = ($urandom_range(3) != 0);
    s.ip = $urandom();
    s.port = 16'($urandom_range(65535));
    s.known = 0;
    s.want_srv = 0;
    s.want_none = 0;
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !hold_off && !(recv_stall > 0 && $urandom_range(99) < recv_stall);
      if (rsp.valid && rsp.ready) begin
        if (pending_choices.size() == 0) begin
          $error("result with no lookup outstanding");
          errors++;
        end else begin
          choice_t c;
          c = pending_choices.pop_front();
          if (rsp.selected_server !== c.srv) begin
            $error("selected_server expected %0d actual %0d", c.srv, rsp.selected_server);
            errors++;
          end
          if (rsp.none_avail !== c.none) begin
            $error("none_avail expected %0d actual %0d", c.none, rsp.none_avail);
            errors++;
          end
          lookups_seen++;
          if (c.none) none_seen++;
        end
      end
    end
  end

  stim_t directed [] = '{
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h0000_0000, 16'h0000, 1, 4'd0, 1'b1},
    '{whss_pkg::OP_UPDATE, 4'd0, 8'd0, 1'b1, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'hffff_ffff, 16'hffff, 1, 4'd0, 1'b0},
    '{whss_pkg::OP_UPDATE, 4'd15, 8'd255, 1'b1, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h1234_5678, 16'habcd, 1, 4'd0, 1'b0},
    '{whss_pkg::OP_UPDATE, 4'd0, 8'd0, 1'b0, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h8000_0001, 16'h8001, 1, 4'd0, 1'b1}
  };

  stim_t wide_rows [] = '{
    '{whss_pkg::OP_UPDATE, 4'd3, 8'd255, 1'b1, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_UPDATE, 4'd7, 8'd1, 1'b1, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_UPDATE, 4'd15, 8'd0, 1'b1, 32'h0, 16'h0, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h0000_0000, 16'h0000, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h0000_00ff, 16'hff00, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'h0102_0408, 16'h55aa, 0, 4'd0, 1'b0},
    '{whss_pkg::OP_LOOKUP, 4'd0, 8'd0, 1'b0, 32'hffff_ffff, 16'hffff, 0, 4'd0, 1'b0}
  };

  initial begin
    m_count = 1;
    m_mixing = 0;
    m_valid = 0;
    for (int k = 0; k < whss_pkg::MAX_SERVERS; k++) begin
      m_weight[k] = 0;
      m_avail[k] = 0;
    end
    req.valid = 1'b0;
    req.op = whss_pkg::OP_UPDATE;
    req.server_index = '0;
    req.server_weight = '0;
    req.server_available = 1'b0;
    req.client_ip = '0;
    req.client_port = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    write_register(whss_pkg::CFG_SERVER_COUNT, 5'd0);
    send_item(wide_rows[3]);
    write_register(whss_pkg::CFG_SERVER_COUNT, 5'd16);
    write_register(whss_pkg::CFG_PORT_MIXING, 5'd1);
    foreach (wide_rows[i]) send_item(wide_rows[i]);

    for (int phase = 0; phase < 8; phase++) begin
      int count_val;
      count_val = (phase == 0) ? 16 : (phase == 1) ? 1 : (phase == 2) ? 31 :
                  $urandom_range(17);
      write_register(whss_pkg::CFG_SERVER_COUNT, count_val[4:0]);
      write_register(whss_pkg::CFG_PORT_MIXING, {4'd0, phase[0]});
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 71; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 71; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      if (phase == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 250; i++) begin
        // Mostly lookups so that the rebuilt table is reused between updates.
        send_item(random_item((i % 50 < 8) ? 60 : 5));
      end
    end

    req.valid <= 1'b0;
    wait (pending_choices.size() == 0);
    repeat (700) @(posedge clk);
    $display("Checked %0d lookups (%0d with no server) over 8 register settings,",
             lookups_seen, none_seen);
    $display("with sender gaps, receiver stalls and a long receiver hold-off.");
    if (errors == 0 && pending_choices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
